// File: rtl/trapezoid_integral_pi_kernel_assert.svh
// Assertion macros for the trapezoid integration kernel.
`ifndef TRAPEZOID_INTEGRAL_PI_KERNEL_ASSERT_SVH
`define TRAPEZOID_INTEGRAL_PI_KERNEL_ASSERT_SVH

// same-cycle implication, clk / arst_n of the enclosing module
`define TIP_ASSERT_IMPLY(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TIP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tip_pkg.sv
// Package: types and constants of the trapezoid integration kernel.
`default_nettype none

package tip_pkg;

	localparam int MAX_TRAPEZOIDS_DEF = 65536;

	localparam int IN_W    = 32;
	localparam int CNT_IN_W = 17;
	localparam int OUT_W   = 48;
	localparam int FRAC    = 24;
	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int FAR_SHIFT = 37;
	localparam int SQ_W    = 50;
	localparam int DEN_W   = 51;
	localparam int F_W     = 27;
	localparam int DIV_BITS = F_W;
	localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);
	localparam int DIV_INIT = 23;

	localparam logic [63:0] POS_MAX48 = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MAG48 = 64'h0000_8000_0000_0000;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ABS,
		S_SQ0,
		S_SQ1,
		S_SQ2,
		S_SQ3,
		S_DIV,
		S_DIVW,
		S_ACC,
		S_PR0,
		S_PR1,
		S_PR2,
		S_DONE
	} tip_state_t;

	typedef enum logic [1:0] {
		PH_LEFT,
		PH_RIGHT,
		PH_INT
	} tip_phase_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tip_div_sts_t;

endpackage

`default_nettype wire

// File: rtl/tip_mul.sv
// Shared unsigned 32x32 multiplier with registered product.
`default_nettype none

module tip_mul (
	input  wire logic                         clk,
	input  wire logic [tip_pkg::MUL_W-1:0]    op_a,
	input  wire logic [tip_pkg::MUL_W-1:0]    op_b,
	output logic      [tip_pkg::PROD_W-1:0]   prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= tip_pkg::PROD_W'(op_a) * tip_pkg::PROD_W'(op_b);
	end

endmodule

`default_nettype wire

// File: rtl/tip_div.sv
// Radix-2 restoring divider: quotient of 2^50 by a 51-bit denominator.
`default_nettype none

module tip_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tip_pkg::DEN_W-1:0]   den,
	output logic      [tip_pkg::F_W-1:0]     quo_q,
	output tip_pkg::tip_div_sts_t            sts
);

	logic [tip_pkg::DEN_W-1:0]     den_q;
	logic [tip_pkg::DEN_W-1:0]     rem_q;
	logic [tip_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [tip_pkg::DEN_W:0]       trial;
	logic                          fits;

	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tip_pkg::DIV_CNT_W'(tip_pkg::DIV_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - tip_pkg::DIV_CNT_W'(1);
				if (cnt_q == tip_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend 2^50: top part seeds the remainder, the rest shifts in as zeros
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= tip_pkg::DEN_W'(1) << tip_pkg::DIV_INIT;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? tip_pkg::DEN_W'(trial - {1'b0, den_q})
				: tip_pkg::DEN_W'(trial);
			quo_q <= {quo_q[tip_pkg::F_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

`default_nettype wire

// File: rtl/trapezoid_integral_pi_kernel.sv
// Top level: trapezoid-rule integration of 4/(1+x*x) in fixed point.
//
//  channel | signals                                               | dir
//  in      | in_valid, in_ready, left_end, right_end,              | in
//          | trapezoid_count, step_width                           |
//  out     | out_valid, out_ready, integral_estimate, saturated    | out
//
// One transaction at a time; in_ready is high only while idle.
// Each sample passes through the 27-step shared divider (far samples,
// |x| >= 2^37, skip the squaring and the divider). Samples = 2 + max(N-1, 0),
// where N is the count clipped to MAX_TRAPEZOIDS; the product is formed last.
// A finished result sits in the output register; a new transaction is taken
// meanwhile, and the block stalls at the end only if that result is not taken.
// Reset (arst_n, asynchronous) returns the sequencer to idle with no result.
`default_nettype none

`include "trapezoid_integral_pi_kernel_assert.svh"

module trapezoid_integral_pi_kernel #(
	parameter int MAX_TRAPEZOIDS = tip_pkg::MAX_TRAPEZOIDS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [tip_pkg::IN_W-1:0]   left_end,
	input  wire logic signed [tip_pkg::IN_W-1:0]   right_end,
	input  wire logic [tip_pkg::CNT_IN_W-1:0]      trapezoid_count,
	input  wire logic signed [tip_pkg::IN_W-1:0]   step_width,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [tip_pkg::OUT_W-1:0]       integral_estimate,
	output logic                                   saturated
);

	localparam int CW = $clog2(MAX_TRAPEZOIDS + 1);
	localparam int XW = 33 + CW;
	localparam int AW = 27 + $clog2(MAX_TRAPEZOIDS);
	localparam int PW = AW + 9;
	localparam int A_W = tip_pkg::FAR_SHIFT;

	tip_pkg::tip_state_t state_q, state_d;
	tip_pkg::tip_phase_t phase_q, phase_d;

	logic signed [tip_pkg::IN_W-1:0] left_q, right_q, step_q;
	logic [CW-1:0]                   count_q, i_q, i_nxt;
	logic signed [XW-1:0]            x_q;
	logic [XW-1:0]                   a_full;
	logic [63:0]                     a64;
	logic                            far;
	logic [A_W-1:0]                  a_q;
	logic                            far_q;
	logic [tip_pkg::SQ_W-1:0]        sq_q;
	logic [AW-1:0]                   acc_q;
	logic [AW:0]                     half_sum;
	logic [tip_pkg::F_W-1:0]         f_val;
	logic [PW-1:0]                   prod_q;
	logic [tip_pkg::MUL_W-1:0]       mag;
	logic [tip_pkg::MUL_W-1:0]       mul_a, mul_b;
	logic [tip_pkg::PROD_W-1:0]      mul_p;
	logic                            div_start;
	logic [tip_pkg::DEN_W-1:0]       div_den;
	logic [tip_pkg::F_W-1:0]         div_quo;
	tip_pkg::tip_div_sts_t           div_sts;
	logic                            accept;
	logic                            emit;
	logic [63:0]                     prod64, clip;
	logic                            sat_c;
	logic [tip_pkg::OUT_W-1:0]       res_c;
	logic [31:0]                     cnt_ext;
	logic                            out_valid_q;

	assign accept = in_valid && in_ready;
	assign emit   = (state_q == tip_pkg::S_DONE) && (!out_valid_q || out_ready);

	assign a_full = x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
	assign a64    = 64'(a_full);
	assign far    = a64 >= (64'd1 << tip_pkg::FAR_SHIFT);
	assign f_val  = far_q ? '0 : div_quo;
	assign half_sum = (AW+1)'(acc_q) + (AW+1)'(f_val);
	assign i_nxt  = i_q + CW'(1);
	assign mag    = step_q[tip_pkg::IN_W-1] ? (~step_q + tip_pkg::MUL_W'(1)) : step_q;
	assign div_den = tip_pkg::DEN_W'(sq_q) + (tip_pkg::DEN_W'(1) << tip_pkg::FRAC);
	assign cnt_ext = 32'(trapezoid_count);

	assign prod64 = 64'(prod_q);
	always_comb begin
		if (step_q[tip_pkg::IN_W-1]) begin
			sat_c = prod64 > tip_pkg::NEG_MAG48;
			clip  = sat_c ? tip_pkg::NEG_MAG48 : prod64;
			res_c = tip_pkg::OUT_W'(64'd0 - clip);
		end else begin
			sat_c = prod64 > tip_pkg::POS_MAX48;
			clip  = sat_c ? tip_pkg::POS_MAX48 : prod64;
			res_c = tip_pkg::OUT_W'(clip);
		end
	end

	tip_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (mul_p)
	);

	tip_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (div_den),
		.quo_q  (div_quo),
		.sts    (div_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tip_pkg::S_IDLE;
			phase_q     <= tip_pkg::PH_LEFT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			tip_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = tip_pkg::S_ABS;
					phase_d = tip_pkg::PH_LEFT;
				end
			end
			tip_pkg::S_ABS: state_d = far ? tip_pkg::S_ACC : tip_pkg::S_SQ0;
			tip_pkg::S_SQ0: begin
				mul_a   = tip_pkg::MUL_W'(a_q[tip_pkg::FRAC-1:0]);
				mul_b   = tip_pkg::MUL_W'(a_q[tip_pkg::FRAC-1:0]);
				state_d = tip_pkg::S_SQ1;
			end
			tip_pkg::S_SQ1: begin
				mul_a   = tip_pkg::MUL_W'(a_q[A_W-1:tip_pkg::FRAC]);
				mul_b   = tip_pkg::MUL_W'(a_q[tip_pkg::FRAC-1:0]);
				state_d = tip_pkg::S_SQ2;
			end
			tip_pkg::S_SQ2: begin
				mul_a   = tip_pkg::MUL_W'(a_q[A_W-1:tip_pkg::FRAC]);
				mul_b   = tip_pkg::MUL_W'(a_q[A_W-1:tip_pkg::FRAC]);
				state_d = tip_pkg::S_SQ3;
			end
			tip_pkg::S_SQ3: state_d = tip_pkg::S_DIV;
			tip_pkg::S_DIV: begin
				div_start = 1'b1;
				state_d   = tip_pkg::S_DIVW;
			end
			tip_pkg::S_DIVW: if (div_sts.done) state_d = tip_pkg::S_ACC;
			tip_pkg::S_ACC: begin
				unique case (phase_q)
					tip_pkg::PH_LEFT: begin
						phase_d = tip_pkg::PH_RIGHT;
						state_d = tip_pkg::S_ABS;
					end
					tip_pkg::PH_RIGHT: begin
						if (count_q > CW'(1)) begin
							phase_d = tip_pkg::PH_INT;
							state_d = tip_pkg::S_ABS;
						end else begin
							state_d = tip_pkg::S_PR0;
						end
					end
					default: state_d = (i_nxt < count_q) ? tip_pkg::S_ABS : tip_pkg::S_PR0;
				endcase
			end
			tip_pkg::S_PR0: begin
				mul_a   = tip_pkg::MUL_W'(acc_q[AW-1:tip_pkg::FRAC]);
				mul_b   = mag;
				state_d = tip_pkg::S_PR1;
			end
			tip_pkg::S_PR1: begin
				mul_a   = tip_pkg::MUL_W'(acc_q[tip_pkg::FRAC-1:0]);
				mul_b   = mag;
				state_d = tip_pkg::S_PR2;
			end
			tip_pkg::S_PR2: state_d = tip_pkg::S_DONE;
			tip_pkg::S_DONE: if (emit) state_d = tip_pkg::S_IDLE;
			default: state_d = tip_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tip_pkg::S_IDLE: begin
				if (in_valid) begin
					left_q  <= left_end;
					right_q <= right_end;
					step_q  <= step_width;
					count_q <= CW'((cnt_ext > 32'(MAX_TRAPEZOIDS)) ?
						32'(MAX_TRAPEZOIDS) : cnt_ext);
					x_q     <= XW'(left_end);
				end
			end
			tip_pkg::S_ABS: begin
				a_q   <= a64[A_W-1:0];
				far_q <= far;
			end
			tip_pkg::S_SQ1: sq_q <= tip_pkg::SQ_W'(mul_p >> tip_pkg::FRAC);
			tip_pkg::S_SQ2: sq_q <= sq_q + tip_pkg::SQ_W'(mul_p << 1);
			tip_pkg::S_SQ3: sq_q <= sq_q + tip_pkg::SQ_W'(mul_p << tip_pkg::FRAC);
			tip_pkg::S_ACC: begin
				case (phase_q)
					tip_pkg::PH_LEFT: begin
						acc_q <= AW'(f_val);
						x_q   <= XW'(right_q);
					end
					tip_pkg::PH_RIGHT: begin
						acc_q <= AW'(half_sum >> 1);
						x_q   <= XW'(left_q) + XW'(step_q);
						i_q   <= CW'(1);
					end
					default: begin
						acc_q <= acc_q + AW'(f_val);
						x_q   <= x_q + XW'(step_q);
						i_q   <= i_nxt;
					end
				endcase
			end
			tip_pkg::S_PR1: prod_q <= PW'(mul_p);
			tip_pkg::S_PR2: prod_q <= prod_q + PW'(mul_p >> tip_pkg::FRAC);
			tip_pkg::S_DONE: begin
				if (emit) begin
					integral_estimate <= res_c;
					saturated         <= sat_c;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

	`TIP_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready, "ready high after accepting a transaction")
	`TIP_ASSERT_IMPLY(a_div_owned, div_sts.busy || div_sts.done, state_q == tip_pkg::S_DIVW, "divider active outside its wait state")
	`TIP_ASSERT_IMPLY(a_sat_at_bound, out_valid && saturated, integral_estimate == 48'sh7FFF_FFFF_FFFF || integral_estimate == 48'sh8000_0000_0000, "saturated result not at a bound")

endmodule

`default_nettype wire

// File: tb/trapezoid_integral_pi_kernel_checker.sv
// Checker: predicts each integration estimate and compares it with the output channel.
module trapezoid_integral_pi_kernel_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [tip_pkg::IN_W-1:0]   left_end,
	input  logic signed [tip_pkg::IN_W-1:0]   right_end,
	input  logic [tip_pkg::CNT_IN_W-1:0]      trapezoid_count,
	input  logic signed [tip_pkg::IN_W-1:0]   step_width,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [tip_pkg::OUT_W-1:0]  integral_estimate,
	input  logic                              saturated,
	output int                                mismatches,
	output int                                outstanding
);

	typedef struct packed {
		logic [tip_pkg::OUT_W-1:0] estimate;
		logic                      clipped;
	} estimate_t;

	estimate_t pending_estimates[$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// 4/(1+x*x) in unsigned Q.24, truncated; zero once |x| >= 2^37
	function automatic logic [63:0] curve_sample(input longint x);
		logic [63:0] mag, hi, lo, sq, den;
		mag = (x < 0) ? 64'(-x) : 64'(x);
		if (mag >= (64'd1 << tip_pkg::FAR_SHIFT))
			return 64'd0;
		hi = mag >> tip_pkg::FRAC;
		lo = mag & 64'hFF_FFFF;
		sq = ((hi * hi) << tip_pkg::FRAC) + 64'd2 * hi * lo + ((lo * lo) >> tip_pkg::FRAC);
		den = (64'd1 << tip_pkg::FRAC) + sq;
		return (64'd1 << 50) / den;
	endfunction

	function automatic estimate_t integrate(
		input logic signed [tip_pkg::IN_W-1:0] lft,
		input logic signed [tip_pkg::IN_W-1:0] rgt,
		input logic [tip_pkg::CNT_IN_W-1:0]    cnt,
		input logic signed [tip_pkg::IN_W-1:0] stp
	);
		estimate_t  res;
		longint     left_x, step_x, i;
		logic [63:0] n, acc, mag, prod;
		logic        neg;
		left_x = lft;
		step_x = stp;
		n = (cnt > tip_pkg::MAX_TRAPEZOIDS_DEF) ? 64'(tip_pkg::MAX_TRAPEZOIDS_DEF) : 64'(cnt);
		acc = (curve_sample(left_x) + curve_sample(longint'(rgt))) >> 1;
		for (i = 1; i < n; i++)
			acc += curve_sample(left_x + i * step_x);
		neg = stp < 0;
		mag = neg ? 64'(-step_x) : 64'(step_x);
		prod = (acc >> tip_pkg::FRAC) * mag + (((acc & 64'hFF_FFFF) * mag) >> tip_pkg::FRAC);
		res.clipped = 1'b0;
		if (neg) begin
			if (prod > tip_pkg::NEG_MAG48) begin
				prod = tip_pkg::NEG_MAG48;
				res.clipped = 1'b1;
			end
			prod = 64'd0 - prod;
		end else begin
			if (prod > tip_pkg::POS_MAX48) begin
				prod = tip_pkg::POS_MAX48;
				res.clipped = 1'b1;
			end
		end
		res.estimate = prod[tip_pkg::OUT_W-1:0];
		return res;
	endfunction

	always @(posedge clk) begin
		estimate_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_estimates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected transaction: est=%h sat=%b",
							$time, integral_estimate, saturated);
				end else begin
					want = pending_estimates.pop_front();
					if (integral_estimate !== want.estimate || saturated !== want.clipped) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch: expected est=%h sat=%b, got est=%h sat=%b",
								$time, want.estimate, want.clipped,
								integral_estimate, saturated);
					end
				end
			end
			if (in_valid && in_ready)
				pending_estimates.push_back(integrate(left_end, right_end,
					trapezoid_count, step_width));
			outstanding = pending_estimates.size();
		end
	end

endmodule

// File: tb/tb_trapezoid_integral_pi_kernel.sv
// Testbench top: stimulus, output drain and verdict for the trapezoid integration kernel.
module tb_trapezoid_integral_pi_kernel;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_ready;
	logic signed [tip_pkg::IN_W-1:0]   left_end = '0;
	logic signed [tip_pkg::IN_W-1:0]   right_end = '0;
	logic [tip_pkg::CNT_IN_W-1:0]      trapezoid_count = '0;
	logic signed [tip_pkg::IN_W-1:0]   step_width = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [tip_pkg::OUT_W-1:0]  integral_estimate;
	logic                              saturated;
	int                                mismatches;
	int                                outstanding;
	int                                requests_sent = 0;

	trapezoid_integral_pi_kernel uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.left_end         (left_end),
		.right_end        (right_end),
		.trapezoid_count  (trapezoid_count),
		.step_width       (step_width),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.integral_estimate(integral_estimate),
		.saturated        (saturated)
	);

	trapezoid_integral_pi_kernel_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.left_end         (left_end),
		.right_end        (right_end),
		.trapezoid_count  (trapezoid_count),
		.step_width       (step_width),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.integral_estimate(integral_estimate),
		.saturated        (saturated),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#120_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// called at a falling edge; returns at the falling edge after the transaction
	task automatic send_request(
		input logic signed [tip_pkg::IN_W-1:0] lft,
		input logic signed [tip_pkg::IN_W-1:0] rgt,
		input logic [tip_pkg::CNT_IN_W-1:0]    cnt,
		input logic signed [tip_pkg::IN_W-1:0] stp
	);
		int gap;
		gap = ((requests_sent / 10) % 4 == 3) ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		left_end <= lft;
		right_end <= rgt;
		trapezoid_count <= cnt;
		step_width <= stp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		requests_sent++;
		@(negedge clk);
	endtask

	// output side; one long hold-off fills the block and stalls its input
	initial begin : drain
		int stall;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (taken == 30)
				stall = 20000;
			else if ((taken / 8) % 3 == 2)
				stall = 0;
			else
				stall = $urandom_range(0, 16);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			taken++;
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int                              k;
		int                              pick;
		logic                            sgn;
		logic signed [tip_pkg::IN_W-1:0] lft, rgt, stp;
		logic [tip_pkg::CNT_IN_W-1:0]    cnt;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// pi over [0,1]
		send_request(32'sh0000_0000, 32'sh0100_0000, 17'd16, 32'sh0010_0000);
		send_request(32'sh0000_0000, 32'sh0100_0000, 17'd256, 32'sh0001_0000);
		// zero count, extreme ends and steps
		send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 17'd0, 32'sh7FFF_FFFF);
		send_request(32'sh0000_0000, 32'sh0000_0000, 17'd0, 32'sh8000_0000);
		send_request(32'sh7FFF_FFFF, 32'sh8000_0000, 17'd1, 32'sh0100_0000);
		send_request(32'sh0000_0000, 32'sh0000_0000, 17'd2, 32'sh0000_0000);
		// interior samples run far from the origin
		send_request(32'sh8000_0000, 32'sh7FFF_FFFF, 17'd200, 32'sh7FFF_FFFF);
		send_request(32'sh7FFF_FFFF, 32'sh0000_0000, 17'd150, 32'sh8000_0000);
		// count clipped to the maximum, and exactly the maximum
		send_request(32'sh0000_0000, 32'sh7FFF_FFFF, 17'h1FFFF, 32'sh7FFF_FFFF);
		send_request(32'sh8000_0000, 32'sh0000_0000, 17'h10000, 32'sh8000_0000);
		// negative and tiny steps
		send_request(32'sh0100_0000, 32'sh0000_0000, 17'd16, 32'shFFF0_0000);
		send_request(32'sh0000_0000, 32'sh0000_0000, 17'd8, 32'sh0000_0001);
		send_request(32'sh0000_0000, 32'sh0000_0000, 17'd8, 32'shFFFF_FFFF);
		send_request(32'($urandom), 32'($urandom), 17'd3, 32'($urandom));

		for (k = 0; k < 100; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				// long run with a coarse step: most samples are far
				cnt = 17'($urandom);
				sgn = 1'($urandom);
				stp = {sgn, ~sgn, 30'($urandom)};
				lft = 32'($urandom);
				rgt = 32'($urandom);
			end else if (pick < 50) begin
				// consistent interval: right = left + count*step
				cnt = 17'($urandom_range(1, 48));
				stp = 32'($urandom_range(0, 32'h0040_0000));
				if ($urandom_range(0, 1))
					stp = -stp;
				lft = $signed(32'($urandom)) >>> $urandom_range(4, 12);
				rgt = lft + $signed({15'd0, cnt}) * stp;
			end else if (pick < 80) begin
				cnt = 17'($urandom_range(0, 48));
				lft = 32'($urandom);
				rgt = 32'($urandom);
				stp = 32'($urandom);
			end else begin
				cnt = 17'($urandom_range(0, 300));
				lft = 32'($urandom);
				rgt = 32'($urandom);
				stp = $signed(32'($urandom)) >>> $urandom_range(0, 31);
			end
			send_request(lft, rgt, cnt, stp);
		end

		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (64) @(negedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tip_pkg.sv
rtl/tip_mul.sv
rtl/tip_div.sv
rtl/trapezoid_integral_pi_kernel.sv
tb/trapezoid_integral_pi_kernel_checker.sv
tb/tb_trapezoid_integral_pi_kernel.sv
